/* rtl/fts_pkg.sv */
// shared types and constants of the frame threshold statistics block
package fts_pkg;

	localparam int SKIP_PIXELS = 10;
	localparam int HISTORY_LEN = 1024;

	localparam int PIX_W    = 10;
	localparam int IDX_W    = 22;
	localparam int SIZE_W   = 23;
	localparam int SUM_W    = 32;
	localparam int MEAN_W   = 16;
	localparam int LOW_W    = 17;
	localparam int FILL_W   = 17;
	localparam int Z_W      = 16;
	localparam int SLOT_W   = 10;
	localparam int FNUM_W   = 31;
	localparam int MEAN_FRAC = 6;
	localparam int FILL_FRAC = 16;

	// divider operand widths: sum << 6 and count << 16 both fit in 38 bits
	localparam int DIVIDEND_W = SUM_W + MEAN_FRAC;
	localparam int DIVISOR_W  = SIZE_W;
	localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

	localparam logic [SIZE_W-1:0] MAX_FRAME   = SIZE_W'(4194304);
	localparam logic [MEAN_W-1:0] PEAK_RESTART = MEAN_W'(100 << MEAN_FRAC);
	localparam logic [LOW_W-1:0]  LOW_RESTART  = LOW_W'(70000);

	localparam logic [PIX_W-1:0]  THRESH_RESET = PIX_W'(300);
	localparam logic [SIZE_W-1:0] FRAME_RESET  = SIZE_W'(3240000);

	// register index, from paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_FRAME     = 1'b1;

	typedef struct packed {
		logic [15:0]        pixel_word;
		logic [FNUM_W-1:0]  frame_number;
		logic signed [Z_W-1:0] frame_z;
		logic               clear_peak;
	} pixel_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  above_count;
		logic [FILL_W-1:0]  fill_fraction;
		logic [MEAN_W-1:0]  mean_above;
		logic [PIX_W-1:0]   frame_maximum;
		logic [MEAN_W-1:0]  peak_mean_out;
		logic [LOW_W-1:0]   low_mean_out;
		logic signed [Z_W-1:0] peak_z_out;
		logic [SLOT_W-1:0]  peak_slot;
		logic               new_peak;
	} stat_t;

	typedef struct packed {
		logic [IDX_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [PIX_W-1:0] max;
	} acc_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_stat_t;

endpackage

/* rtl/fts_divider.sv */
// shared restoring divider, one quotient bit per cycle
module fts_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  fts_pkg::div_ctrl_t ctrl,
	output fts_pkg::div_stat_t status
);
	localparam int N = fts_pkg::DIVIDEND_W;
	localparam int D = fts_pkg::DIVISOR_W;

	logic [D-1:0]                 rem_q;
	logic [N-1:0]                 quo_q;
	logic [D-1:0]                 dsr_q;
	logic [fts_pkg::STEP_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [D:0]                   shifted;
	logic [D:0]                   diff;
	logic                         fits;

	// trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[N-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = !diff[D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= fts_pkg::STEP_W'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fts_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= ctrl.dividend;
			dsr_q <= ctrl.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[D-1:0] : shifted[D-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign status.busy     = busy_q;
	assign status.done     = done_q;
	assign status.quotient = quo_q;

endmodule

/* rtl/fts_accum.sv */
// per-frame pixel index, above-threshold count and sum, and frame maximum
module fts_accum (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [15:0]                    pixel_word,
	input  logic [fts_pkg::PIX_W-1:0]      threshold,
	input  logic [fts_pkg::IDX_W-1:0]      last_index,
	output logic                           frame_end,
	output fts_pkg::acc_t                  acc_next
);
	logic [fts_pkg::IDX_W-1:0] idx_q;
	fts_pkg::acc_t             acc_q;
	logic [fts_pkg::PIX_W-1:0] pix;
	logic                      counted;

	assign pix       = pixel_word[15:16-fts_pkg::PIX_W];
	assign counted   = idx_q >= fts_pkg::IDX_W'(fts_pkg::SKIP_PIXELS);
	assign frame_end = idx_q >= last_index;

	always_comb begin
		acc_next = acc_q;
		if (counted) begin
			if (pix > threshold) begin
				acc_next.count = acc_q.count + 1'b1;
				acc_next.sum   = acc_q.sum + fts_pkg::SUM_W'(pix);
			end
			if (pix > acc_q.max) begin
				acc_next.max = pix;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (take) begin
			if (frame_end) begin
				idx_q <= '0;
				acc_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				acc_q <= acc_next;
			end
		end
	end

endmodule

/* rtl/frame_threshold_statistics.sv */
// top level: pixel intake, frame-end sequencer, peak tracking and register port
//
// Frame threshold statistics. Each pixel word carries a 10-bit pixel in bits
// 15..6; the first 10 pixels of a frame are skipped, the rest are compared
// with pixel_threshold (register 0, byte address 0): pixels strictly above it
// are counted and summed, and the largest pixel of the frame is kept. The
// frame length comes from frame_pixels (register 1, byte address 4), clamped
// to 1..4194304. On the frame's last pixel one stat word goes out with the
// count, the fill fraction count/size in Q0.16, the mean above threshold in
// Q10.6 (zero when nothing passed), the frame maximum, and the running peak
// and lowest positive means with the focus position and slot of the peak.
// clear_peak on any pixel restarts the peak at 100.0 and the low mean at code
// 70000. Timing: every pixel but a frame's last is taken back to back. The
// last pixel hands the frame to a sequencer that runs both divisions on one
// shared restoring divider, 38 quotient bits at one bit per cycle each, and
// pixel_ready stays low until the stat word is loaded into the output register
// (also while the previous stat word still waits to be taken). A stat
// word sits in an output register; pixels keep flowing while it waits.
module frame_threshold_statistics (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel channel
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  fts_pkg::pixel_t       pixel,
	// stat channel
	output logic                  stat_valid,
	input  logic                  stat_ready,
	output fts_pkg::stat_t        stat,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MEAN = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;

	// configuration registers
	logic [fts_pkg::PIX_W-1:0]  thresh_q;
	logic [fts_pkg::SIZE_W-1:0] frame_q;
	logic                       cfg_write;

	// clamped frame size and last pixel position
	logic [fts_pkg::SIZE_W-1:0] frame_size;
	logic [fts_pkg::IDX_W-1:0]  last_index;

	// pixel intake
	logic          take;
	logic          frame_end;
	fts_pkg::acc_t acc_next;

	// frame snapshot held for the sequencer
	fts_pkg::acc_t                  snap_q;
	logic [fts_pkg::SIZE_W-1:0]     size_q;
	logic signed [fts_pkg::Z_W-1:0] z_q;
	logic [fts_pkg::SLOT_W-1:0]     slot_q;
	logic [fts_pkg::MEAN_W-1:0]     mean_q;
	logic [fts_pkg::FILL_W-1:0]     fill_q;

	// running peak tracking
	logic [fts_pkg::MEAN_W-1:0]     peak_mean_q;
	logic [fts_pkg::LOW_W-1:0]      low_mean_q;
	logic signed [fts_pkg::Z_W-1:0] peak_z_q;
	logic [fts_pkg::SLOT_W-1:0]     peak_slot_q;

	// shared divider
	fts_pkg::div_ctrl_t div_ctrl;
	fts_pkg::div_stat_t div_stat;

	// output register
	logic           stat_valid_q;
	fts_pkg::stat_t stat_q;
	logic           emit;
	logic           raise;
	logic           lower;

	// ---------------- register port ----------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= fts_pkg::THRESH_RESET;
			frame_q  <= fts_pkg::FRAME_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				fts_pkg::REG_THRESHOLD: thresh_q <= pwdata[fts_pkg::PIX_W-1:0];
				fts_pkg::REG_FRAME:     frame_q  <= pwdata[fts_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fts_pkg::REG_THRESHOLD: prdata = 32'(thresh_q);
			fts_pkg::REG_FRAME:     prdata = 32'(frame_q);
			default:                prdata = '0;
		endcase
	end

	// zero reads as one pixel, oversize clamps to the largest frame
	always_comb begin
		if (frame_q == '0) begin
			frame_size = fts_pkg::SIZE_W'(1);
		end else if (frame_q > fts_pkg::MAX_FRAME) begin
			frame_size = fts_pkg::MAX_FRAME;
		end else begin
			frame_size = frame_q;
		end
	end
	assign last_index = fts_pkg::IDX_W'(frame_size - 1'b1);

	// ---------------- pixel intake ----------------
	assign pixel_ready = (state_q == S_IDLE);
	assign take        = pixel_valid && pixel_ready;

	fts_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.pixel_word (pixel.pixel_word),
		.threshold  (thresh_q),
		.last_index (last_index),
		.frame_end  (frame_end),
		.acc_next   (acc_next)
	);

	// ---------------- divider sharing ----------------
	// first pass: sum * 64 / count, second pass: count * 65536 / size
	always_comb begin
		div_ctrl.start    = (take && frame_end) || (state_q == S_MEAN && div_stat.done);
		div_ctrl.dividend = '0;
		div_ctrl.divisor  = '0;
		if (state_q == S_IDLE) begin
			div_ctrl.dividend = {acc_next.sum, fts_pkg::MEAN_FRAC'(0)};
			div_ctrl.divisor  = fts_pkg::DIVISOR_W'(acc_next.count);
		end else begin
			div_ctrl.dividend = fts_pkg::DIVIDEND_W'({snap_q.count,
				fts_pkg::FILL_FRAC'(0)});
			div_ctrl.divisor  = size_q;
		end
	end

	fts_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.status (div_stat)
	);

	// ---------------- frame-end sequencer ----------------
	assign emit = (state_q == S_EMIT) && (!stat_valid_q || stat_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (take && frame_end) state_q <= S_MEAN;
				S_MEAN: if (div_stat.done) state_q <= S_FILL;
				S_FILL: if (div_stat.done) state_q <= S_EMIT;
				S_EMIT: if (emit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// frame snapshot and division results
	always_ff @(posedge clk) begin
		if (take && frame_end) begin
			snap_q <= acc_next;
			size_q <= frame_size;
			z_q    <= pixel.frame_z;
			slot_q <= fts_pkg::SLOT_W'(pixel.frame_number % fts_pkg::HISTORY_LEN);
		end
		if (state_q == S_MEAN && div_stat.done) begin
			// no pixel above threshold gives a zero mean
			mean_q <= (snap_q.count == '0) ? '0 : div_stat.quotient[fts_pkg::MEAN_W-1:0];
		end
		if (state_q == S_FILL && div_stat.done) begin
			fill_q <= div_stat.quotient[fts_pkg::FILL_W-1:0];
		end
	end

	// ---------------- peak tracking ----------------
	assign raise = mean_q > peak_mean_q;
	assign lower = !raise && (fts_pkg::LOW_W'(mean_q) < low_mean_q) && (mean_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_mean_q <= '0;
			low_mean_q  <= '0;
			peak_z_q    <= '0;
			peak_slot_q <= '0;
		end else begin
			// restart lands before this frame's update, which runs later
			if (take && pixel.clear_peak) begin
				peak_mean_q <= fts_pkg::PEAK_RESTART;
				low_mean_q  <= fts_pkg::LOW_RESTART;
			end else if (emit) begin
				if (raise) begin
					peak_mean_q <= mean_q;
					peak_z_q    <= z_q;
					peak_slot_q <= slot_q;
				end else if (lower) begin
					low_mean_q <= fts_pkg::LOW_W'(mean_q);
				end
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_valid_q <= 1'b0;
		end else if (emit) begin
			stat_valid_q <= 1'b1;
		end else if (stat_ready) begin
			stat_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			stat_q.above_count   <= fts_pkg::SIZE_W'(snap_q.count);
			stat_q.fill_fraction <= fill_q;
			stat_q.mean_above    <= mean_q;
			stat_q.frame_maximum <= snap_q.max;
			stat_q.peak_mean_out <= raise ? mean_q : peak_mean_q;
			stat_q.low_mean_out  <= lower ? fts_pkg::LOW_W'(mean_q) : low_mean_q;
			stat_q.peak_z_out    <= raise ? z_q : peak_z_q;
			stat_q.peak_slot     <= raise ? slot_q : peak_slot_q;
			stat_q.new_peak      <= raise;
		end
	end

	assign stat_valid = stat_valid_q;
	assign stat       = stat_q;

`ifndef SYNTHESIS
	// the shared divider is only started when idle
	assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.start |-> !div_stat.busy)
		else $error("divider started while busy");

	// a stat word only appears out of the emit step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat_valid) |-> $past(state_q == S_EMIT))
		else $error("stat word raised outside emit");

	// a new peak carries the frame mean as the peak
	assert property (@(posedge clk) disable iff (!arst_n)
		(stat_valid && stat.new_peak) |-> (stat.peak_mean_out == stat.mean_above))
		else $error("new peak does not match frame mean");

	// a positive mean that is no peak never sits below the low mean
	assert property (@(posedge clk) disable iff (!arst_n)
		(stat_valid && !stat.new_peak && stat.mean_above != '0)
		|-> (stat.low_mean_out <= fts_pkg::LOW_W'(stat.mean_above)))
		else $error("low mean above a positive frame mean");
`endif

endmodule

/* verif/stat_checker.sv */
`timescale 1ns / 100ps
// stat word predictor and checker for the frame threshold statistics block
module stat_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	input  logic              pixel_ready,
	input  fts_pkg::pixel_t   pixel,
	input  logic              stat_valid,
	input  logic              stat_ready,
	input  fts_pkg::stat_t    stat,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                failures,
	output int                pending,
	output int                stats_checked
);
	// register copies
	logic [fts_pkg::PIX_W-1:0]  threshold;
	logic [fts_pkg::SIZE_W-1:0] frame_reg;

	// per-frame accumulators
	logic [fts_pkg::IDX_W-1:0]  pos;
	logic [fts_pkg::IDX_W-1:0]  hits;
	logic [fts_pkg::SUM_W-1:0]  hit_sum;
	logic [fts_pkg::PIX_W-1:0]  hi_pix;

	// peak tracking across frames
	logic [fts_pkg::MEAN_W-1:0] best_mean;
	logic [fts_pkg::LOW_W-1:0]  least_mean;
	logic [fts_pkg::Z_W-1:0]    best_z;
	logic [fts_pkg::SLOT_W-1:0] best_slot;

	fts_pkg::stat_t stat_due[$];
	fts_pkg::stat_t want;
	logic [31:0] read_want;

	initial begin
		failures = 0;
		pending = 0;
		stats_checked = 0;
	end

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned exp_val);
		failures++;
		$display("mismatch at %0t: %s got %0h wanted %0h", $time, what, got, exp_val);
	endtask

	task automatic compare_stat(input fts_pkg::stat_t got, input fts_pkg::stat_t exp_val);
		if (got.above_count !== exp_val.above_count)
			report("above_count", got.above_count, exp_val.above_count);
		if (got.fill_fraction !== exp_val.fill_fraction)
			report("fill_fraction", got.fill_fraction, exp_val.fill_fraction);
		if (got.mean_above !== exp_val.mean_above)
			report("mean_above", got.mean_above, exp_val.mean_above);
		if (got.frame_maximum !== exp_val.frame_maximum)
			report("frame_maximum", got.frame_maximum, exp_val.frame_maximum);
		if (got.peak_mean_out !== exp_val.peak_mean_out)
			report("peak_mean_out", got.peak_mean_out, exp_val.peak_mean_out);
		if (got.low_mean_out !== exp_val.low_mean_out)
			report("low_mean_out", got.low_mean_out, exp_val.low_mean_out);
		if (got.peak_z_out !== exp_val.peak_z_out)
			report("peak_z_out", $unsigned(got.peak_z_out), $unsigned(exp_val.peak_z_out));
		if (got.peak_slot !== exp_val.peak_slot)
			report("peak_slot", got.peak_slot, exp_val.peak_slot);
		if (got.new_peak !== exp_val.new_peak)
			report("new_peak", got.new_peak, exp_val.new_peak);
	endtask

	// fold one pixel word into the frame, queue a stat word on the frame's last pixel
	task automatic absorb_pixel(input fts_pkg::pixel_t p);
		logic [fts_pkg::PIX_W-1:0]  v;
		logic [fts_pkg::SIZE_W-1:0] frame_len;
		logic [fts_pkg::SIZE_W-1:0] last_pos;
		logic [63:0]                quot;
		fts_pkg::stat_t             s;
		v = p.pixel_word[15:6];
		frame_len = frame_reg;
		if (frame_len == '0)
			frame_len = fts_pkg::SIZE_W'(1);
		if (frame_len > fts_pkg::MAX_FRAME)
			frame_len = fts_pkg::MAX_FRAME;
		last_pos = frame_len - fts_pkg::SIZE_W'(1);
		if (p.clear_peak) begin
			best_mean = fts_pkg::PEAK_RESTART;
			least_mean = fts_pkg::LOW_RESTART;
		end
		if (pos >= fts_pkg::IDX_W'(fts_pkg::SKIP_PIXELS)) begin
			if (v > threshold) begin
				hits = hits + fts_pkg::IDX_W'(1);
				hit_sum = hit_sum + fts_pkg::SUM_W'(v);
			end
			if (v > hi_pix)
				hi_pix = v;
		end
		if (fts_pkg::SIZE_W'(pos) < last_pos) begin
			pos = pos + fts_pkg::IDX_W'(1);
		end else begin
			s = '0;
			if (hits != '0) begin
				quot = (64'(hit_sum) << fts_pkg::MEAN_FRAC) / 64'(hits);
				s.mean_above = fts_pkg::MEAN_W'(quot);
			end
			quot = (64'(hits) << fts_pkg::FILL_FRAC) / 64'(frame_len);
			s.fill_fraction = fts_pkg::FILL_W'(quot);
			if (s.mean_above > best_mean) begin
				best_mean = s.mean_above;
				best_z = p.frame_z;
				best_slot = p.frame_number[fts_pkg::SLOT_W-1:0];
				s.new_peak = 1'b1;
			end else if (fts_pkg::LOW_W'(s.mean_above) < least_mean
					&& s.mean_above != '0) begin
				least_mean = fts_pkg::LOW_W'(s.mean_above);
			end
			s.above_count = fts_pkg::SIZE_W'(hits);
			s.frame_maximum = hi_pix;
			s.peak_mean_out = best_mean;
			s.low_mean_out = least_mean;
			s.peak_z_out = best_z;
			s.peak_slot = best_slot;
			stat_due.insert(stat_due.size(), s);
			pos = '0;
			hits = '0;
			hit_sum = '0;
			hi_pix = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = fts_pkg::THRESH_RESET;
			frame_reg = fts_pkg::FRAME_RESET;
			pos = '0;
			hits = '0;
			hit_sum = '0;
			hi_pix = '0;
			best_mean = '0;
			least_mean = '0;
			best_z = '0;
			best_slot = '0;
			stat_due.delete();
			pending = 0;
		end else begin
			// register port: writes update the copies, reads must return them
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[2])
						fts_pkg::REG_THRESHOLD: threshold = pwdata[fts_pkg::PIX_W-1:0];
						fts_pkg::REG_FRAME:     frame_reg = pwdata[fts_pkg::SIZE_W-1:0];
					endcase
				end else begin
					read_want = (paddr[2] == fts_pkg::REG_THRESHOLD) ? 32'(threshold)
						: 32'(frame_reg);
					if (prdata !== read_want)
						report("register read", prdata, read_want);
				end
			end
			if (stat_valid && stat_ready) begin
				stats_checked++;
				if (stat_due.size() == 0) begin
					report("stat word with nothing due, mean", stat.mean_above, 0);
				end else begin
					want = stat_due.pop_front();
					compare_stat(stat, want);
				end
			end
			if (pixel_valid && pixel_ready)
				absorb_pixel(pixel);
			pending = stat_due.size();
		end
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// top of the frame threshold statistics testbench: clock, reset, stimulus and verdict
module testbench;
	localparam int SETTLE      = 150;        // cycles after the last stat word before a register write
	localparam int HOLD_CYCLES = 400;        // long receiver hold-off, the pixel stream backs up behind it
	localparam int NUM_PHASES  = 10;
	localparam int PHASE_WORDS = 55;
	localparam int BIG_FRAME   = 257;
	localparam longint LIMIT_NS = 64'd20_000_000;

	logic            clk;
	logic            arst_n;
	logic            pixel_valid;
	logic            pixel_ready;
	fts_pkg::pixel_t pixel;
	logic            stat_valid;
	logic            stat_ready;
	fts_pkg::stat_t  stat;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [2:0]      paddr;
	logic [31:0]     pwdata;
	logic [31:0]     prdata;
	logic            pready;

	int failures;
	int pending;
	int stats_checked;

	// idle rates in percent, changed per phase
	int pix_idle_pct = 0;
	int stat_stall_pct = 0;
	bit hold_req = 1'b0;
	int words_sent = 0;
	int reg_writes = 0;

	frame_threshold_statistics DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.stat_valid  (stat_valid),
		.stat_ready  (stat_ready),
		.stat        (stat),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	stat_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel_valid   (pixel_valid),
		.pixel_ready   (pixel_ready),
		.pixel         (pixel),
		.stat_valid    (stat_valid),
		.stat_ready    (stat_ready),
		.stat          (stat),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.failures      (failures),
		.pending       (pending),
		.stats_checked (stats_checked)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// hard stop in case a stat word never shows up
	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when asked for
	initial begin
		stat_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// hold counted here so the sender keeps pushing meanwhile
				stat_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				stat_ready <= (stat_stall_pct == 0) || ($urandom_range(99) >= stat_stall_pct);
			end
		end
	end

	// register write: setup cycle, access cycle, then bus released
	task automatic reg_write(input logic reg_sel, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		reg_writes++;
	endtask

	// register read, the checker compares prdata with its own copy
	task automatic reg_read(input logic reg_sel);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// offer one pixel word, called and returning at a falling edge
	task automatic send_pixel(input fts_pkg::pixel_t p);
		while (pix_idle_pct != 0 && $urandom_range(99) < pix_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// sender stops until every stat word is back, then lets the block settle
	task automatic quiesce();
		pixel_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic fts_pkg::pixel_t pixel_of(input logic [15:0] word,
			input logic [fts_pkg::FNUM_W-1:0] fnum,
			input logic signed [fts_pkg::Z_W-1:0] z, input logic clr);
		fts_pkg::pixel_t p;
		p.pixel_word = word;
		p.frame_number = fnum;
		p.frame_z = z;
		p.clear_peak = clr;
		return p;
	endfunction

	// random pixel word, mostly close to the threshold so frames straddle it
	function automatic fts_pkg::pixel_t random_pixel(input int thr);
		int v;
		logic [15:0] word;
		if ($urandom_range(4) == 0) begin
			word = 16'($urandom());
		end else begin
			v = thr + $urandom_range(60) - 30;
			if (v < 0)
				v = 0;
			if (v > 1023)
				v = 1023;
			word = {fts_pkg::PIX_W'(v), 6'($urandom())};
		end
		return pixel_of(word, fts_pkg::FNUM_W'($urandom()), fts_pkg::Z_W'($urandom()),
			$urandom_range(99) < 4);
	endfunction

	initial begin
		int thr;
		int frame_len;
		int words;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values of both registers
		reg_read(fts_pkg::REG_THRESHOLD);
		reg_read(fts_pkg::REG_FRAME);

		// frame size zero clamps to one: every word ends a frame, nothing past the skip
		reg_write(fts_pkg::REG_FRAME, 32'd0);
		reg_write(fts_pkg::REG_THRESHOLD, 32'd1023);
		send_pixel(pixel_of(16'hFFFF, '1, 16'sh7FFF, 1'b1));
		quiesce();

		// zero threshold, 11-pixel frames: a full-scale pixel sets a new peak
		reg_write(fts_pkg::REG_THRESHOLD, 32'd0);
		reg_write(fts_pkg::REG_FRAME, 32'd11);
		repeat (10) send_pixel(pixel_of(16'hFFFF, '0, '0, 1'b0));
		send_pixel(pixel_of(16'hFFFF, '1, 16'sh7FFF, 1'b0));
		// skipped words do nothing, the smallest nonzero pixel becomes the low mean
		repeat (10) send_pixel(pixel_of(16'h0000, '0, '0, 1'b0));
		send_pixel(pixel_of(16'h0040, '0, -16'sd32768, 1'b0));
		quiesce();

		// largest frame size (saturated), then shrunk under a frame in progress
		reg_write(fts_pkg::REG_FRAME, 32'h007F_FFFF);
		reg_read(fts_pkg::REG_FRAME);
		repeat (20) send_pixel(random_pixel(0));
		quiesce();
		reg_write(fts_pkg::REG_FRAME, 32'd11);
		send_pixel(random_pixel(0));
		quiesce();

		// random phases, each with its own threshold, frame size and idle pattern
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 0)
				thr = 0;
			else if (ph == 1)
				thr = 1023;
			else
				thr = $urandom_range(1023);
			if (ph == 2)
				frame_len = BIG_FRAME;
			else if (ph == 3)
				frame_len = $urandom_range(1, fts_pkg::SKIP_PIXELS);
			else
				frame_len = $urandom_range(11, 24);
			reg_write(fts_pkg::REG_THRESHOLD, 32'(thr));
			reg_write(fts_pkg::REG_FRAME, 32'(frame_len));
			reg_read(fts_pkg::REG_THRESHOLD);
			reg_read(fts_pkg::REG_FRAME);
			// first phase runs flat out on both sides
			pix_idle_pct = (ph == 0) ? 0 : 29;
			stat_stall_pct = (ph == 0) ? 0 : 29;
			words = (ph == 2) ? BIG_FRAME + 40 : PHASE_WORDS;
			if (ph == 5)
				hold_req = 1'b1;
			for (int n = 0; n < words; n++)
				send_pixel(random_pixel(thr));
			quiesce();
		end

		$display("run covered %0d pixel words, %0d stat words and %0d register writes,",
			words_sent, stats_checked, reg_writes);
		$display("thresholds 0 and 1023, frame sizes 0 to saturated, peak restarts and a long stall");
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
